// ----- hw/rtl/htw_pkg.sv -----
// Shared types and constants for the hierarchical timer wheel.
`default_nettype none
package htw_pkg;
   localparam int OPCODE_W = 1;
   localparam int ID_W     = 5;
   localparam int TICK_W   = 32;
   localparam int ORDER_W  = 16;
   localparam logic [ORDER_W-1:0] ORDER_MAX = 16'hFFFF;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [ID_W-1:0]     timer_id;
      logic [TICK_W-1:0]   expires;
   } req_type;

   typedef struct packed {
      logic            fired;
      logic [ID_W-1:0] fired_id;
      logic            last;
   } rsp_type;
endpackage
`default_nettype wire

// ----- hw/rtl/htw_cmd_queue.sv -----
// Two-entry command queue between the request front and the wheel engine.
`default_nettype none
module htw_cmd_queue
   import htw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    flush,
   input  wire logic    push,
   input  wire req_type push_data,
   output logic         full,
   input  wire logic    pop,
   output req_type      pop_data,
   output logic         empty
);
   req_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset || flush) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/htw_engine.sv -----
// Wheel engine: filing, cascade and fire sequencer over the timer pool.
`default_nettype none
module htw_engine
   import htw_pkg::*;
#(
   parameter int POOL_SIZE  = 32,
   parameter int ROOT_BITS  = 6,
   parameter int LEVEL_BITS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              init,
   input  wire logic [TICK_W-1:0] init_tick,
   input  wire logic              cmd_valid,
   input  wire req_type           cmd,
   output logic                   cmd_pop,
   output logic                   out_push,
   output rsp_type                out_data,
   input  wire logic              out_full
);
   localparam int SLOT_W  = ((ROOT_BITS > LEVEL_BITS + 2) ? ROOT_BITS : LEVEL_BITS + 2) + 1;
   localparam int PIDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int ROOT_SZ = 1 << ROOT_BITS;
   localparam int LVL_SZ  = 1 << LEVEL_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_FILE, ST_RENUM, ST_FIRE
   } state_type;

   state_type              state_ff;
   logic [TICK_W-1:0]      tick_ff;
   logic [POOL_SIZE-1:0]   pend_ff;
   logic [POOL_SIZE-1:0]   member_ff;
   logic [TICK_W-1:0]      expiry_ff [POOL_SIZE];
   logic [SLOT_W-1:0]      slot_ff   [POOL_SIZE];
   logic [ORDER_W-1:0]     order_ff  [POOL_SIZE];
   logic [ORDER_W-1:0]     ctr_ff;
   logic [2:0]             level_ff;      // 0 = fire scan, 1..4 = cascade level
   logic [SLOT_W-1:0]      target_ff;
   logic [PIDX_W-1:0]      scan_ff;
   logic                   best_ok_ff;
   logic [PIDX_W-1:0]      best_ff;
   logic [PIDX_W-1:0]      file_id_ff;
   logic                   file_add_ff;   // filing from an add, not a cascade
   logic [PIDX_W-1:0]      ren_i_ff, ren_j_ff;
   logic [ORDER_W-1:0]     rank_ff;
   logic [ORDER_W-1:0]     ren_n_ff;
   logic [ORDER_W-1:0]     new_ord_ff [POOL_SIZE];
   logic                   fired_any_ff;
   rsp_type                hold_ff;
   logic                   hold_ok_ff;

   // slot computation for the entry being filed
   logic [TICK_W-1:0] fe, delta;
   logic [SLOT_W-1:0] fslot;
   always_comb begin
      fe    = expiry_ff[file_id_ff];
      delta = fe - tick_ff;
      if (delta < TICK_W'(ROOT_SZ))
         fslot = SLOT_W'(fe[ROOT_BITS-1:0]);
      else if (delta < (TICK_W'(1) << (ROOT_BITS + LEVEL_BITS)))
         fslot = SLOT_W'(ROOT_SZ) + SLOT_W'(fe[ROOT_BITS +: LEVEL_BITS]);
      else if (delta < (TICK_W'(1) << (ROOT_BITS + 2*LEVEL_BITS)))
         fslot = SLOT_W'(ROOT_SZ + LVL_SZ) + SLOT_W'(fe[ROOT_BITS+LEVEL_BITS +: LEVEL_BITS]);
      else if (delta < (TICK_W'(1) << (ROOT_BITS + 3*LEVEL_BITS)))
         fslot = SLOT_W'(ROOT_SZ + 2*LVL_SZ)
               + SLOT_W'(fe[ROOT_BITS+2*LEVEL_BITS +: LEVEL_BITS]);
      else if (delta[TICK_W-1])
         fslot = SLOT_W'(tick_ff[ROOT_BITS-1:0]);
      else
         fslot = SLOT_W'(ROOT_SZ + 3*LVL_SZ)
               + SLOT_W'(fe[ROOT_BITS+3*LEVEL_BITS +: LEVEL_BITS]);
   end

   function automatic logic [SLOT_W-1:0] lvl_slot(input logic [2:0] lv,
                                                    input logic [TICK_W-1:0] t);
      logic [LEVEL_BITS-1:0] ix;
      ix = LEVEL_BITS'(t >> (ROOT_BITS + (int'(lv) - 1) * LEVEL_BITS));
      return SLOT_W'(ROOT_SZ) + SLOT_W'((int'(lv) - 1) * LVL_SZ) + SLOT_W'(ix);
   endfunction

   function automatic logic lvl_idx_zero(input logic [2:0] lv,
                                         input logic [TICK_W-1:0] t);
      logic [LEVEL_BITS-1:0] ix;
      ix = LEVEL_BITS'(t >> (ROOT_BITS + (int'(lv) - 1) * LEVEL_BITS));
      return ix == '0;
   endfunction

   logic scan_last;
   logic is_mem, better;
   assign scan_last = (scan_ff == PIDX_W'(POOL_SIZE - 1));
   assign is_mem    = pend_ff[scan_ff] && (slot_ff[scan_ff] == target_ff);
   assign better    = !best_ok_ff || (order_ff[scan_ff] < order_ff[best_ff]);

   logic id_ok;
   assign id_ok = ({1'b0, cmd.timer_id} < (ID_W+1)'(POOL_SIZE));

   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid && !init;
   assign out_push = hold_ok_ff && !out_full;
   assign out_data = hold_ff;

   always_ff @(posedge clock) begin
      if (out_push) hold_ok_ff <= 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               if (op_type'(cmd.opcode) == OP_ADD) begin
                  if (id_ok) begin
                     expiry_ff[PIDX_W'(cmd.timer_id)] <= cmd.expires;
                     file_id_ff  <= PIDX_W'(cmd.timer_id);
                     file_add_ff <= 1'b1;
                     state_ff    <= (ctr_ff >= ORDER_MAX) ? ST_RENUM : ST_FILE;
                     ren_i_ff    <= '0;
                     ren_j_ff    <= '0;
                     rank_ff     <= '0;
                     ren_n_ff    <= '0;
                  end
               end else begin
                  fired_any_ff <= 1'b0;
                  scan_ff      <= '0;
                  best_ok_ff   <= 1'b0;
                  member_ff    <= '0;
                  if (tick_ff[ROOT_BITS-1:0] == '0) begin
                     level_ff  <= 3'd1;
                     target_ff <= lvl_slot(3'd1, tick_ff);
                  end else begin
                     level_ff  <= 3'd0;
                     target_ff <= SLOT_W'(tick_ff[ROOT_BITS-1:0]);
                     tick_ff   <= tick_ff + 1'b1;
                  end
                  state_ff <= ST_SEARCH;
               end
            end
         end
         // Sweep the pool for the oldest member of target slot not yet taken.
         // For cascades, the first sweep snapshots membership.
         ST_SEARCH: begin
            if (is_mem && !(level_ff != 3'd0 && member_ff[scan_ff] == 1'b0
                            && fired_any_ff) && better) begin
               best_ok_ff <= 1'b1;
               best_ff    <= scan_ff;
            end
            if (level_ff != 3'd0 && !fired_any_ff && is_mem)
               member_ff[scan_ff] <= 1'b1;
            scan_ff <= scan_ff + 1'b1;
            if (scan_last) begin
               scan_ff <= '0;
               fired_any_ff <= (level_ff != 3'd0) ? 1'b1 : fired_any_ff;
               if (level_ff == 3'd0) begin
                  if (best_ok_ff || (is_mem && better)) begin
                     state_ff <= ST_FIRE;
                  end else if (!hold_ok_ff || out_push) begin
                     if (!fired_any_ff) begin
                        hold_ff    <= '{fired: 1'b0, fired_id: '0, last: 1'b1};
                        hold_ok_ff <= 1'b1;
                     end else begin
                        hold_ff.last <= 1'b1;
                        hold_ok_ff   <= 1'b1;
                     end
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  if (best_ok_ff || (is_mem && better && (member_ff[scan_ff]
                                                          || !fired_any_ff))) begin
                     file_id_ff  <= (best_ok_ff && !(is_mem && better &&
                                     (member_ff[scan_ff] || !fired_any_ff)))
                                    ? best_ff : scan_ff;
                     file_add_ff <= 1'b0;
                     ren_i_ff <= '0; ren_j_ff <= '0; rank_ff <= '0; ren_n_ff <= '0;
                     state_ff <= (ctr_ff >= ORDER_MAX) ? ST_RENUM : ST_FILE;
                  end else if (level_ff != 3'd4 && lvl_idx_zero(level_ff, tick_ff)) begin
                     level_ff     <= level_ff + 1'b1;
                     target_ff    <= lvl_slot(level_ff + 1'b1, tick_ff);
                     fired_any_ff <= 1'b0;
                     member_ff    <= '0;
                     best_ok_ff   <= 1'b0;
                  end else begin
                     level_ff     <= 3'd0;
                     target_ff    <= SLOT_W'(tick_ff[ROOT_BITS-1:0]);
                     tick_ff      <= tick_ff + 1'b1;
                     fired_any_ff <= 1'b0;
                     best_ok_ff   <= 1'b0;
                  end
               end
            end
         end
         // Renumber orders: rank of entry i counted over j, one pair a cycle.
         ST_RENUM: begin
            if (pend_ff[ren_i_ff] && pend_ff[ren_j_ff]
                && order_ff[ren_j_ff] < order_ff[ren_i_ff])
               rank_ff <= rank_ff + 1'b1;
            ren_j_ff <= ren_j_ff + 1'b1;
            if (ren_j_ff == PIDX_W'(POOL_SIZE - 1)) begin
               ren_j_ff <= '0;
               rank_ff  <= '0;
               new_ord_ff[ren_i_ff] <= rank_ff + ORDER_W'(pend_ff[ren_i_ff] &&
                  pend_ff[ren_j_ff] && order_ff[ren_j_ff] < order_ff[ren_i_ff]);
               if (pend_ff[ren_i_ff]) ren_n_ff <= ren_n_ff + 1'b1;
               ren_i_ff <= ren_i_ff + 1'b1;
               if (ren_i_ff == PIDX_W'(POOL_SIZE - 1)) begin
                  for (int k = 0; k < POOL_SIZE; k++) begin
                     if (pend_ff[k]) order_ff[k] <= (k == POOL_SIZE - 1) ?
                        rank_ff + ORDER_W'(pend_ff[ren_i_ff] && pend_ff[ren_j_ff]
                        && order_ff[ren_j_ff] < order_ff[ren_i_ff]) : new_ord_ff[k];
                  end
                  ctr_ff   <= ren_n_ff + ORDER_W'(pend_ff[ren_i_ff]);
                  state_ff <= ST_FILE;
               end
            end
         end
         ST_FILE: begin
            slot_ff[file_id_ff]  <= fslot;
            order_ff[file_id_ff] <= ctr_ff;
            ctr_ff               <= ctr_ff + 1'b1;
            pend_ff[file_id_ff]  <= 1'b1;
            member_ff[file_id_ff] <= 1'b0;
            best_ok_ff <= 1'b0;
            scan_ff    <= '0;
            state_ff   <= file_add_ff ? ST_IDLE : ST_SEARCH;
         end
         // Release the staged report with last clear first, then stage the new one
         // once the holding register frees up.
         ST_FIRE: begin
            if (!hold_ok_ff && fired_any_ff) begin
               hold_ok_ff <= 1'b1;
            end else if (!hold_ok_ff || out_push) begin
               hold_ff      <= '{fired: 1'b1, fired_id: ID_W'(best_ff), last: 1'b0};
               hold_ok_ff   <= 1'b0;
               pend_ff[best_ff] <= 1'b0;
               fired_any_ff <= 1'b1;
               best_ok_ff   <= 1'b0;
               scan_ff      <= '0;
               state_ff     <= ST_SEARCH;
            end
         end
         default: state_ff <= ST_IDLE;
      endcase
      if (reset) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= '0;
         ctr_ff     <= '0;
         tick_ff    <= '0;
         hold_ok_ff <= 1'b0;
      end else if (init) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= '0;
         ctr_ff     <= '0;
         tick_ff    <= init_tick;
         hold_ok_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/htw_out_queue.sv -----
// Result queue holding tick reports until taken.
`default_nettype none
module htw_out_queue
   import htw_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   input  wire logic    pop,
   output rsp_type      pop_data,
   output logic         empty
);
   localparam int AW = $clog2(DEPTH);
   rsp_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/hierarchical_timer_wheel_unit.sv -----
// Top level of the hierarchical timer wheel: front queue, engine, result queue.
// Add: the engine files the timer, renumbering orders first when the order counter reaches ORDER_MAX.
// Tick: the engine sequences pool scans for each level cascaded, each cascaded timer and
//   each fired timer; result stalls hold it.
// Reset clears all timers, order counter and tick (start_tick = 0); a start_tick
//   write reloads the tick and empties the wheel.
`default_nettype none
module hierarchical_timer_wheel_unit
   import htw_pkg::*;
#(
   parameter int POOL_SIZE  = 32,
   parameter int ROOT_BITS  = 6,
   parameter int LEVEL_BITS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   output logic             rsp_empty,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   logic [TICK_W-1:0] start_tick_ff;
   logic              cfg_wr;
   logic              q_empty, q_pop, o_push, o_full;
   req_type           q_data;
   rsp_type           o_data;

   assign pready = 1'b1;
   // Only register 0 exists; other addresses are ignored.
   assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
   assign prdata = (paddr == 2'd0) ? start_tick_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) start_tick_ff <= '0;
      else if (cfg_wr) start_tick_ff <= pwdata;
   end

   htw_cmd_queue u_cmdq (
      .clock, .reset, .flush(cfg_wr),
      .push(req_push), .push_data(req_data), .full(req_full),
      .pop(q_pop), .pop_data(q_data), .empty(q_empty)
   );

   htw_engine #(
      .POOL_SIZE(POOL_SIZE), .ROOT_BITS(ROOT_BITS), .LEVEL_BITS(LEVEL_BITS)
   ) u_engine (
      .clock, .reset, .init(cfg_wr), .init_tick(pwdata),
      .cmd_valid(!q_empty), .cmd(q_data), .cmd_pop(q_pop),
      .out_push(o_push), .out_data(o_data), .out_full(o_full)
   );

   htw_out_queue #(.DEPTH(4)) u_outq (
      .clock, .reset,
      .push(o_push), .push_data(o_data), .full(o_full),
      .pop(rsp_pop), .pop_data(rsp_data), .empty(rsp_empty)
   );
endmodule
`default_nettype wire

// ----- tb/hierarchical_timer_wheel_unit_checker.sv -----
// Scoreboard for the timer wheel: mirrors the wheel state and checks every fired-timer report.
`default_nettype none
module hierarchical_timer_wheel_unit_checker
   import htw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire req_type     req_data,
   input  wire logic        rsp_pop,
   input  wire logic        rsp_empty,
   input  wire rsp_type     rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic        pready,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output int               fault_count,
   output int               due_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMERS     = 32;
   localparam int ROOT_SLOTS = 64;
   localparam int LVL_SLOTS  = 16;
   localparam logic [1:0] START_TICK_ADDR = 2'd0;

   logic [31:0] wheel_tick;
   bit          armed [TIMERS];
   logic [31:0] deadline [TIMERS];
   logic [8:0]  slot_of [TIMERS];
   logic [15:0] seq_of [TIMERS];
   logic [15:0] seq_next;
   rsp_type     fire_q [$];

   function automatic void wheel_clear(input logic [31:0] t);
      for (int i = 0; i < TIMERS; i++) begin
         armed[i] = 0;
         deadline[i] = '0;
         slot_of[i] = '0;
         seq_of[i] = '0;
      end
      seq_next = '0;
      wheel_tick = t;
   endfunction

   // Compact filing orders to 0..n-1, keeping their sequence.
   function automatic void reseq();
      logic [15:0] rank [TIMERS];
      logic [15:0] n;
      n = 0;
      for (int i = 0; i < TIMERS; i++) begin
         rank[i] = 0;
         if (armed[i]) begin
            n++;
            for (int j = 0; j < TIMERS; j++)
               if (armed[j] && seq_of[j] < seq_of[i]) rank[i]++;
         end
      end
      for (int i = 0; i < TIMERS; i++)
         if (armed[i]) seq_of[i] = rank[i];
      seq_next = n;
   endfunction

   function automatic void file_timer(input int id);
      logic [31:0] e;
      logic [31:0] delta;
      logic [8:0]  s;
      e = deadline[id];
      delta = e - wheel_tick;
      if (delta < 32'd64)          s = {3'd0, e[5:0]};
      else if (delta < 32'd1024)   s = 9'(ROOT_SLOTS + e[9:6]);
      else if (delta < 32'd16384)  s = 9'(ROOT_SLOTS + LVL_SLOTS + e[13:10]);
      else if (delta < 32'd262144) s = 9'(ROOT_SLOTS + 2*LVL_SLOTS + e[17:14]);
      else if (delta[31])          s = {3'd0, wheel_tick[5:0]};
      else                         s = 9'(ROOT_SLOTS + 3*LVL_SLOTS + e[21:18]);
      slot_of[id] = s;
      if (seq_next >= ORDER_MAX) reseq();
      seq_of[id] = seq_next;
      seq_next++;
      armed[id] = 1;
   endfunction

   function automatic int oldest(input bit [TIMERS-1:0] m);
      int best;
      best = -1;
      for (int i = 0; i < TIMERS; i++)
         if (m[i] && (best < 0 || seq_of[i] < seq_of[best])) best = i;
      return best;
   endfunction

   // Pull the whole slot out first, then re-file oldest first.
   function automatic void cascade(input int lvl, input logic [3:0] idx);
      bit [TIMERS-1:0] m;
      int pick;
      for (int i = 0; i < TIMERS; i++)
         m[i] = armed[i] && slot_of[i] == 9'(ROOT_SLOTS + (lvl-1)*LVL_SLOTS + idx);
      pick = oldest(m);
      while (pick >= 0) begin
         m[pick] = 0;
         file_timer(pick);
         pick = oldest(m);
      end
   endfunction

   function automatic void advance();
      logic [5:0] idx;
      bit [TIMERS-1:0] m;
      int pick;
      rsp_type r;
      idx = wheel_tick[5:0];
      if (idx == 0) begin
         cascade(1, wheel_tick[9:6]);
         if (wheel_tick[9:6] == 0) begin
            cascade(2, wheel_tick[13:10]);
            if (wheel_tick[13:10] == 0) begin
               cascade(3, wheel_tick[17:14]);
               if (wheel_tick[17:14] == 0) cascade(4, wheel_tick[21:18]);
            end
         end
      end
      wheel_tick++;
      for (int i = 0; i < TIMERS; i++) m[i] = armed[i] && slot_of[i] == {3'd0, idx};
      pick = oldest(m);
      if (pick < 0) begin
         r = '{fired: 1'b0, fired_id: '0, last: 1'b1};
         fire_q.push_back(r);
      end
      while (pick >= 0) begin
         m[pick] = 0;
         armed[pick] = 0;
         r = '{fired: 1'b1, fired_id: 5'(pick), last: 1'b0};
         pick = oldest(m);
         if (pick < 0) r.last = 1'b1;
         fire_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wheel_clear('0);
         fire_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (fire_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: unexpected result fired=%0b id=%0d last=%0b", $realtime,
                           rsp_data.fired, rsp_data.fired_id, rsp_data.last);
            end else begin
               want = fire_q.pop_front();
               if (rsp_data.fired !== want.fired || rsp_data.fired_id !== want.fired_id ||
                   rsp_data.last !== want.last) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("%0t: mismatch exp fired=%0b id=%0d last=%0b, got %0b/%0d/%0b",
                              $realtime, want.fired, want.fired_id, want.last,
                              rsp_data.fired, rsp_data.fired_id, rsp_data.last);
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == START_TICK_ADDR)
            wheel_clear(pwdata);
         if (req_push && !req_full) begin
            if (req_data.opcode == OP_ADD) begin
               deadline[req_data.timer_id] = req_data.expires;
               file_timer(int'(req_data.timer_id));
            end else begin
               advance();
            end
         end
      end
      due_count = fire_q.size();
   end
endmodule
`default_nettype wire

// ----- tb/hierarchical_timer_wheel_unit_tb.sv -----
// Testbench top for the timer wheel: clock, reset, stimulus, watchdog and verdict.
`default_nettype none
module hierarchical_timer_wheel_unit_tb;
   import htw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] START_TICK_ADDR = 2'd0;
   // Longest quiet stretch: a full cascade of the pool plus a renumbering add,
   // stretched by the receiver's stalls, with ample margin.
   localparam int QUIET_LIMIT = 60000;
   // Adds report nothing, so let a renumbering add finish before touching the register.
   localparam int SETTLE_CYCLES = 1200;

   logic        clock;
   logic        reset;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        rsp_empty;
   logic        psel, penable, pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          fault_count;
   int          due_count;
   int          tx_idle_pct;
   int          rx_idle_pct;
   int          quiet_cycles;
   logic [31:0] wheel_now;   // tick the wheel should hold, tracked for stimulus only

   hierarchical_timer_wheel_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_data(rsp_data), .rsp_empty(rsp_empty),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   hierarchical_timer_wheel_unit_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .fault_count(fault_count), .due_count(due_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Receiver: stall at random according to the current idle rate.
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Watchdog: restart the count on any transaction or register access.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("hierarchical_timer_wheel_unit_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one transaction; return at the edge that accepts it.
   task automatic push_item(input req_type item);
      logic was_full;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do begin
         @(negedge clock);
         was_full = req_full;
         @(posedge clock);
      end while (was_full);
      if (item.opcode == OP_TICK) wheel_now++;
   endtask

   task automatic send_add(input logic [4:0] id, input logic [31:0] exp_tick);
      push_item('{opcode: OP_ADD, timer_id: id, expires: exp_tick});
   endtask

   task automatic send_tick();
      push_item('{opcode: OP_TICK, timer_id: 5'($urandom), expires: $urandom});
   endtask

   // Hold off until every report has drained and the engine has gone quiet.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      wait (due_count == 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_tick(input logic [31:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= START_TICK_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      wheel_now = value;
   endtask

   // Random add: near expiries most often so timers fire, the rest spread over every level,
   // the past and the whole 32-bit range.
   task automatic random_add();
      int          pick;
      logic [31:0] exp_tick;
      pick = $urandom_range(99);
      if (pick < 40)      exp_tick = wheel_now + $urandom_range(0, 63);
      else if (pick < 62) exp_tick = wheel_now + $urandom_range(64, 1023);
      else if (pick < 72) exp_tick = wheel_now + $urandom_range(1024, 16383);
      else if (pick < 80) exp_tick = wheel_now + $urandom_range(16384, 262143);
      else if (pick < 86) exp_tick = wheel_now + $urandom_range(262144, 32'h7FFF_FFFF);
      else if (pick < 94) exp_tick = wheel_now - $urandom_range(1, 2000);
      else                exp_tick = $urandom;
      send_add(5'($urandom_range(0, 31)), exp_tick);
   endtask

   initial begin
      int tx_rates [3];
      int rx_rates [3];
      logic [31:0] start_val;
      tx_rates = '{16, 77, 0};
      rx_rates = '{77, 16, 0};
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      tx_idle_pct = tx_rates[0];
      rx_idle_pct = rx_rates[0];
      wheel_now = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: one timer per level boundary, the past, a re-add, then the first ticks.
      send_add(5'd0, 32'd0);
      send_add(5'd31, 32'hFFFF_FFFF);
      send_add(5'd5, 32'd63);
      send_add(5'd6, 32'd64);
      send_add(5'd7, 32'd1023);
      send_add(5'd8, 32'd1024);
      send_add(5'd9, 32'd16383);
      send_add(5'd10, 32'd16384);
      send_add(5'd11, 32'd262144);
      send_add(5'd12, 32'h7FFF_FFFF);
      send_add(5'd5, 32'd2);
      send_add(5'd13, 32'd1);
      repeat (4) send_tick();
      // Tick counter wrap: every level index becomes zero, so all four levels cascade.
      write_start_tick(32'hFFFF_FFFF);
      send_add(5'd1, 32'd0);
      send_add(5'd2, 32'd5);
      send_add(5'd3, 32'd300);
      send_add(5'd4, 32'h0004_0000);
      send_add(5'd20, 32'hFFFF_FFFF);
      repeat (3) send_tick();

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = tx_rates[ph];
         rx_idle_pct = rx_rates[ph];
         for (int blk = 0; blk < 3; blk++) begin
            // Start just short of a level-four wrap, anywhere, or at an extreme.
            if (blk == 0)      start_val = ($urandom << 18) - $urandom_range(1, 20);
            else if (blk == 1) start_val = $urandom;
            else               start_val = (ph == 1) ? 32'd0 : 32'hFFFF_FFC0;
            write_start_tick(start_val);
            for (int k = 0; k < 40; k++) begin
               if (ph == 0 && blk == 0 && k == 20) drain();
               if ($urandom_range(99) < 55) random_add();
               else send_tick();
            end
         end
      end

      drain();
      if (fault_count == 0) begin
         $display("hierarchical_timer_wheel_unit_tb: done, clean");
      end else begin
         $display("hierarchical_timer_wheel_unit_tb: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
